### rtl/core/cksd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cksd_pkg
// Shared types and constants of the color key side detector.
// ----------------------------------------------------------------------------
package cksd_pkg;

	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 3;
	localparam int TOTAL_W     = 20;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BLUE    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_GREEN   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_RED     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 3'd5;

	// register reset values
	localparam logic [10:0] RST_FRAME_WIDTH = 11'd640;
	localparam logic [7:0]  RST_KEY_BLUE    = 8'd24;
	localparam logic [7:0]  RST_KEY_GREEN   = 8'd47;
	localparam logic [7:0]  RST_KEY_RED     = 8'd157;
	localparam logic [7:0]  RST_TOLERANCE   = 8'd20;
	localparam logic [19:0] RST_THRESHOLD   = 20'd50;

	// object side codes
	localparam logic [1:0] SIDE_NONE   = 2'd0;
	localparam logic [1:0] SIDE_LEFT   = 2'd1;
	localparam logic [1:0] SIDE_RIGHT  = 2'd2;
	localparam logic [1:0] SIDE_PASSED = 2'd3;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [7:0]  key_blue;
		logic [7:0]  key_green;
		logic [7:0]  key_red;
		logic [7:0]  tolerance;
		logic [19:0] count_threshold;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         side;
		logic [TOTAL_W-1:0] left_total;
		logic [TOTAL_W-1:0] right_total;
	} tally_t;

endpackage
`default_nettype wire

### rtl/core/color_key_side_detector_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_key_side_detector_unit
// Color key pixel matcher with left/right object side verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (in_valid / in_stall): one BGR pixel per transaction with
//   row_end and frame_end marks. Result channel (out_valid / out_stall): one
//   transaction per pixel, the pixel blacked out when it matched the key,
//   plus the verdict fields (fresh when verdict_valid is set on frame end).
//   Config port: cfg_we / cfg_index / cfg_data, written only while idle; the
//   user must keep to that, the block has no check for it. Path: input
//   register, then result register. Throughput: one pixel per cycle unless
//   the result channel stalls; the match test, one counter increment and
//   the total/threshold compare sit between the two registers.
//   Reset: registers return to their defaults (width 640, key 24/47/157,
//   tolerance 20, threshold 50), counts and column clear, side is none.
//   Stall: a held result keeps its values; the input register still takes
//   one more pixel, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module color_key_side_detector_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int COUNT_BITS = 20
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// config write port
	input  wire logic                             cfg_we,
	input  wire logic [cksd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [cksd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// pixel channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       blue,
	input  wire logic [7:0]                       green,
	input  wire logic [7:0]                       red,
	input  wire logic                             row_end,
	input  wire logic                             frame_end,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [7:0]                            out_blue,
	output logic [7:0]                            out_green,
	output logic [7:0]                            out_red,
	output logic                                  matched,
	output logic                                  verdict_valid,
	output logic [1:0]                            object_side,
	output logic [cksd_pkg::TOTAL_W-1:0]          left_total,
	output logic [cksd_pkg::TOTAL_W-1:0]          right_total
);

	cksd_pkg::cfg_t   cfg;
	cksd_pkg::tally_t tally;

	// input register
	logic       valid_s1;
	logic [7:0] blue_s1, green_s1, red_s1;
	logic       row_end_s1, frame_end_s1;

	// result register
	logic                         valid_s2;
	logic [7:0]                   blue_s2, green_s2, red_s2;
	logic                         matched_s2, verdict_s2;
	logic [1:0]                   side_s2;
	logic [cksd_pkg::TOTAL_W-1:0] left_s2, right_s2;

	logic hit;
	logic advance;   // s1 transaction moves into the result register
	logic take_in;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	cksd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cksd_match u_match (
		.blue  (blue_s1),
		.green (green_s1),
		.red   (red_s1),
		.cfg   (cfg),
		.hit   (hit)
	);

	// state only moves when the s1 pixel is committed to the result register
	cksd_tally #(
		.MAX_WIDTH  (MAX_WIDTH),
		.COUNT_BITS (COUNT_BITS)
	) u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.hit       (hit),
		.row_end   (row_end_s1),
		.frame_end (frame_end_s1),
		.cfg       (cfg),
		.result    (tally)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			blue_s1      <= blue;
			green_s1     <= green;
			red_s1       <= red;
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blue_s2    <= hit ? 8'd0 : blue_s1;
			green_s2   <= hit ? 8'd0 : green_s1;
			red_s2     <= hit ? 8'd0 : red_s1;
			matched_s2 <= hit;
			verdict_s2 <= frame_end_s1;
			side_s2    <= tally.side;
			left_s2    <= tally.left_total;
			right_s2   <= tally.right_total;
		end
	end

	assign out_valid     = valid_s2;
	assign out_blue      = blue_s2;
	assign out_green     = green_s2;
	assign out_red       = red_s2;
	assign matched       = matched_s2;
	assign verdict_valid = verdict_s2;
	assign object_side   = side_s2;
	assign left_total    = left_s2;
	assign right_total   = right_s2;

	// input backpressure only comes from a stalled, full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// a matched pixel always leaves blacked out
	a_match_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && matched) |-> (out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0))
		else $error("matched pixel not blacked out");

	// result drains when taken and nothing is pending in the input register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result repeated");

endmodule
`default_nettype wire

### rtl/core/cksd_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cksd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module cksd_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [cksd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [cksd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output cksd_pkg::cfg_t                        cfg
);

	cksd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= cksd_pkg::RST_FRAME_WIDTH;
			cfg_q.key_blue        <= cksd_pkg::RST_KEY_BLUE;
			cfg_q.key_green       <= cksd_pkg::RST_KEY_GREEN;
			cfg_q.key_red         <= cksd_pkg::RST_KEY_RED;
			cfg_q.tolerance       <= cksd_pkg::RST_TOLERANCE;
			cfg_q.count_threshold <= cksd_pkg::RST_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cksd_pkg::CFG_FRAME_WIDTH: cfg_q.frame_width     <= cfg_data[10:0];
				cksd_pkg::CFG_KEY_BLUE:    cfg_q.key_blue        <= cfg_data[7:0];
				cksd_pkg::CFG_KEY_GREEN:   cfg_q.key_green       <= cfg_data[7:0];
				cksd_pkg::CFG_KEY_RED:     cfg_q.key_red         <= cfg_data[7:0];
				cksd_pkg::CFG_TOLERANCE:   cfg_q.tolerance       <= cfg_data[7:0];
				cksd_pkg::CFG_THRESHOLD:   cfg_q.count_threshold <= cfg_data[19:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### rtl/core/cksd_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cksd_match
// Per-pixel key color test: every channel strictly within tolerance.
// ----------------------------------------------------------------------------
module cksd_match (
	input  wire logic [7:0]    blue,
	input  wire logic [7:0]    green,
	input  wire logic [7:0]    red,
	input  wire cksd_pkg::cfg_t cfg,
	output logic               hit
);

	function automatic logic near_key(input logic [7:0] v, input logic [7:0] k,
			input logic [7:0] tol);
		logic [7:0] d;
		d = (v >= k) ? (v - k) : (k - v);
		return d < tol;
	endfunction

	assign hit = near_key(blue, cfg.key_blue, cfg.tolerance)
		&& near_key(green, cfg.key_green, cfg.tolerance)
		&& near_key(red, cfg.key_red, cfg.tolerance);

endmodule
`default_nettype wire

### rtl/core/cksd_tally.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cksd_tally
// Column tracking, saturating half-frame counts and the frame-end verdict.
// ----------------------------------------------------------------------------
module cksd_tally #(
	parameter int MAX_WIDTH  = 1024,
	parameter int COUNT_BITS = 20
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire logic           hit,
	input  wire logic           row_end,
	input  wire logic           frame_end,
	input  wire cksd_pkg::cfg_t cfg,
	output cksd_pkg::tally_t    result
);

	localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMPW = (CW > 10) ? CW : 10;
	localparam int TW   = (COUNT_BITS + 1 > 20) ? COUNT_BITS + 1 : 20;

	logic [CW-1:0]         column_q;
	logic [COUNT_BITS-1:0] left_q;
	logic [COUNT_BITS-1:0] right_q;
	logic [1:0]            side_q;

	logic                  in_left;
	logic [COUNT_BITS-1:0] left_next;
	logic [COUNT_BITS-1:0] right_next;
	logic [TW-1:0]         total;
	logic [TW-1:0]         thr;
	logic [1:0]            side_next;

	always_comb begin
		in_left    = CMPW'(column_q) < CMPW'(cfg.frame_width[10:1]);
		left_next  = left_q;
		right_next = right_q;
		if (hit && in_left && (left_q != {COUNT_BITS{1'b1}}))
			left_next = left_q + 1'b1;
		if (hit && !in_left && (right_q != {COUNT_BITS{1'b1}}))
			right_next = right_q + 1'b1;
		total = TW'(left_next) + TW'(right_next);
		thr   = TW'(cfg.count_threshold);
		priority if (total > thr)
			side_next = (left_next > right_next) ? cksd_pkg::SIDE_LEFT : cksd_pkg::SIDE_RIGHT;
		else if ((total < thr)
				&& ((side_q == cksd_pkg::SIDE_LEFT) || (side_q == cksd_pkg::SIDE_RIGHT)))
			side_next = cksd_pkg::SIDE_PASSED;
		else
			side_next = cksd_pkg::SIDE_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			left_q   <= '0;
			right_q  <= '0;
			side_q   <= cksd_pkg::SIDE_NONE;
		end else if (advance) begin
			if (frame_end) begin
				left_q  <= '0;
				right_q <= '0;
				side_q  <= side_next;
			end else begin
				left_q  <= left_next;
				right_q <= right_next;
			end
			if (row_end || frame_end)
				column_q <= '0;
			else if (column_q < CW'(MAX_WIDTH - 1))
				column_q <= column_q + 1'b1;
		end
	end

	assign result.side        = frame_end ? side_next : side_q;
	assign result.left_total  = cksd_pkg::TOTAL_W'(left_next);
	assign result.right_total = cksd_pkg::TOTAL_W'(right_next);

endmodule
`default_nettype wire
